// ----- rtl/sus_pkg.sv -----
`default_nettype none

package sus_pkg;

    // Sizes of the index space and of the class set
    localparam int MAX_INDICES = 65536;
    localparam int MAX_CLASSES = 8;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 16;
    localparam int LAB_W   = 3;
    localparam int QUOTA_W = 16;
    localparam int CCNT_W  = 4;
    localparam int SIZE_W  = 17;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 17;

    // Index space actually held in the bit maps
    localparam int MEM_INDICES = (MAX_INDICES < 65536) ? MAX_INDICES : 65536;
    localparam int ROW_BITS    = (MEM_INDICES < 64) ? MEM_INDICES : 64;
    localparam int BIT_W       = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
    localparam int ROWS        = (MEM_INDICES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_AW      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_FORBID = 2'd1;
    localparam logic [OP_W-1:0] OP_CAND   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_QUOTA   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CLASSES = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ONE     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SIZE    = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              capture;
        logic              clr_used;
        logic              clr_forb;
        logic              commit;
        logic [ROW_AW-1:0] clr_addr;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_start;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/stratified_unique_sampler.sv -----
// Stratified sampler without replacement.
//
// Input channel s_*: one item per handshake. s_tuser carries the operation
// (start a sample, forbid an index, offer a candidate, no operation);
// s_tdata carries the index and the class label. Every item gives exactly
// one result on m_*: accepted flag, echoed index and label, done status and
// the number of indices taken into the current sample.
// Configuration: cfg_we writes register cfg_addr (quota, class count,
// one-class mode, dataset size) at the clock edge; write only when idle.
// Timing: a forbid, candidate or no-operation item is held and evaluated in
// the EVAL state against the bit map rows read at acceptance; its result is
// registered there, and no new item is taken until that result is presented.
// The read-modify-write of one 64-bit row of the bit maps is done in EVAL.
// A start item sweeps the 1024 rows of the used map one row a cycle and
// then passes through EVAL, which registers its result.
// Reset: rst_n clears the counters and control state and loads the config
// defaults; the block then clears the 1024 rows of both maps with s_tready low.
// Stall: a result waits in the output register while m_tready is low; the
// next item is taken as soon as the result leaves in that same cycle.
`default_nettype none

module stratified_unique_sampler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [sus_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [sus_pkg::CFG_DW-1:0]  cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [15:0] sample_index, [18:16] class_label, [23:19] zero
    input  wire logic [23:0]                 s_tdata,
    // [1:0] op
    input  wire logic [sus_pkg::OP_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] accepted, [16:1] chosen_index, [19:17] chosen_label,
    // [20] sample_done, [37:21] taken_total, [39:38] zero
    output logic [39:0]                      m_tdata
);
    import sus_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              out_accepted;
    logic [IDX_W-1:0]  out_index;
    logic [LAB_W-1:0]  out_label;
    logic              out_done;
    logic [SIZE_W-1:0] out_taken;

    sus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sus_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_op        (s_tuser),
        .in_idx       (s_tdata[15:0]),
        .in_lab       (s_tdata[18:16]),
        .cmd          (cmd),
        .status       (status),
        .out_accepted (out_accepted),
        .out_index    (out_index),
        .out_label    (out_label),
        .out_done     (out_done),
        .out_taken    (out_taken)
    );

    // Pack the result
    assign m_tdata = {2'b00, out_taken, out_done, out_label, out_index, out_accepted};

endmodule

`default_nettype wire

// ----- rtl/sus_ctrl.sv -----
`default_nettype none

module sus_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire sus_pkg::status_t status,
    output sus_pkg::cmd_t        cmd
);
    import sus_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    logic [1:0]        state_reg, state_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              accept;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Sequence the sweeps and the evaluation step
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        cmd          = '0;
        cmd.clr_addr = row_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_used = 1'b1;
                cmd.clr_forb = 1'b1;
                row_next     = row_reg + 1'b1;
                if (row_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    row_next    = '0;
                    state_next  = status.in_start ? ST_CLEAR : ST_EVAL;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_used = 1'b1;
                row_next     = row_reg + 1'b1;
                if (row_reg == LAST_ROW)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Hold a result until the receiver takes it
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !m_tvalid_reg)
        else $error("result loaded while previous result still held");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.in_start) |=> (state_reg == ST_CLEAR) && (row_reg == '0))
        else $error("start item did not begin the used map sweep");

    a_eval_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |=> (state_reg == ST_IDLE) && m_tvalid_reg)
        else $error("evaluation did not present a result");

endmodule

`default_nettype wire

// ----- rtl/sus_datapath.sv -----
`default_nettype none

module sus_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [sus_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [sus_pkg::CFG_DW-1:0]  cfg_data,
    input  wire logic [sus_pkg::OP_W-1:0]    in_op,
    input  wire logic [sus_pkg::IDX_W-1:0]   in_idx,
    input  wire logic [sus_pkg::LAB_W-1:0]   in_lab,
    input  wire sus_pkg::cmd_t               cmd,
    output sus_pkg::status_t                 status,
    output logic                             out_accepted,
    output logic [sus_pkg::IDX_W-1:0]        out_index,
    output logic [sus_pkg::LAB_W-1:0]        out_label,
    output logic                             out_done,
    output logic [sus_pkg::SIZE_W-1:0]       out_taken
);
    import sus_pkg::*;

    localparam logic [SIZE_W-1:0] MEM_SIZE = SIZE_W'(MEM_INDICES);
    localparam logic [CCNT_W-1:0] CLS_MAX  = CCNT_W'(MAX_CLASSES);

    // Configuration registers
    logic [QUOTA_W-1:0] quota_reg;
    logic [CCNT_W-1:0]  classes_reg;
    logic               one_reg;
    logic [SIZE_W-1:0]  size_reg;

    // Sample state
    logic [QUOTA_W-1:0] cnt_reg [MAX_CLASSES];
    logic [SIZE_W-1:0]  taken_reg;
    logic [SIZE_W-1:0]  forb_total_reg;

    // Held item and bit map rows
    logic [OP_W-1:0]     op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [LAB_W-1:0]    lab_reg;
    logic [ROW_BITS-1:0] used_mem [ROWS];
    logic [ROW_BITS-1:0] forb_mem [ROWS];
    logic [ROW_BITS-1:0] used_rd_reg;
    logic [ROW_BITS-1:0] forb_rd_reg;

    // Look-ahead status terms, registered ahead of the evaluation step
    logic [MAX_CLASSES-1:0] ge0_reg, ge1_reg;
    logic                   sum_ge_reg, sum1_ge_reg, pre_done_reg;

    logic [SIZE_W-1:0]      eff_size;
    logic [CCNT_W-1:0]      eff_cls;
    logic                   no_cls;
    logic [MAX_CLASSES-1:0] in_use, ge0_c, ge1_c, sel_ge;
    logic [SIZE_W:0]        sum_c;
    logic                   sum_ge_c, sum1_ge_c, done_now;
    logic [ROW_AW-1:0]      rd_row, row;
    logic [BIT_W-1:0]       bit_sel;
    logic [ROW_BITS-1:0]    mask;
    logic [CNT_AW-1:0]      slot;
    logic                   idx_ok, lab_ok, used_bit, forb_bit;
    logic                   is_cand, is_forb, take, forb_inc, full_next, done_next;

    assign status.in_start = (in_op == OP_START);

    // Clamp the configured sizes
    assign eff_size = (size_reg > MEM_SIZE) ? MEM_SIZE : size_reg;
    assign eff_cls  = (int'(classes_reg) > MAX_CLASSES) ? CLS_MAX : classes_reg;
    assign no_cls   = (eff_cls == '0);

    // Compare every counter against the quota, now and after one more
    always_comb
    begin
        for (int c = 0; c < MAX_CLASSES; c++)
        begin
            in_use[c] = (c < int'(eff_cls));
            ge0_c[c]  = (cnt_reg[c] >= quota_reg);
            ge1_c[c]  = (({1'b0, cnt_reg[c]} + 17'd1) >= {1'b0, quota_reg});
        end
    end

    assign sum_c     = {1'b0, taken_reg} + {1'b0, forb_total_reg};
    assign sum_ge_c  = (sum_c >= {1'b0, eff_size});
    assign sum1_ge_c = ((sum_c + 18'd1) >= {1'b0, eff_size});
    assign done_now  = no_cls || (one_reg ? ge0_c[0] : &(ge0_c | ~in_use)) || sum_ge_c;

    // Decode the held item against the rows read at accept
    assign rd_row   = ROW_AW'(in_idx >> BIT_W);
    assign row      = ROW_AW'(idx_reg >> BIT_W);
    assign bit_sel  = idx_reg[BIT_W-1:0];
    assign mask     = ROW_BITS'(1) << bit_sel;
    assign used_bit = used_rd_reg[bit_sel];
    assign forb_bit = forb_rd_reg[bit_sel];
    assign slot     = one_reg ? '0 : CNT_AW'(lab_reg);
    assign idx_ok   = ({1'b0, idx_reg} < eff_size);
    assign lab_ok   = ({1'b0, lab_reg} < eff_cls);
    assign is_cand  = (op_reg == OP_CAND);
    assign is_forb  = (op_reg == OP_FORBID);
    assign take     = is_cand && !pre_done_reg && idx_ok && lab_ok &&
                      !ge0_reg[slot] && !used_bit && !forb_bit;
    assign forb_inc = is_forb && idx_ok && !forb_bit;

    // Work out the done status after this item
    always_comb
    begin
        for (int c = 0; c < MAX_CLASSES; c++)
        begin
            sel_ge[c] = (take && (CNT_AW'(c) == slot)) ? ge1_reg[c] : ge0_reg[c];
        end
    end

    assign full_next = no_cls || (one_reg ? sel_ge[0] : &(sel_ge | ~in_use));
    assign done_next = full_next || ((take || forb_inc) ? sum1_ge_reg : sum_ge_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_reg   <= QUOTA_W'(1);
            classes_reg <= CCNT_W'(2);
            one_reg     <= 1'b0;
            size_reg    <= SIZE_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_QUOTA:   quota_reg   <= cfg_data[QUOTA_W-1:0];
                CFG_CLASSES: classes_reg <= cfg_data[CCNT_W-1:0];
                CFG_ONE:     one_reg     <= cfg_data[0];
                CFG_SIZE:    size_reg    <= cfg_data[SIZE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Advance counters and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                cnt_reg[c] <= '0;
            end
            taken_reg      <= '0;
            forb_total_reg <= '0;
        end
        else
        begin
            if (cmd.capture && status.in_start)
            begin
                for (int c = 0; c < MAX_CLASSES; c++)
                begin
                    cnt_reg[c] <= '0;
                end
                taken_reg <= '0;
            end
            else if (cmd.commit && take)
            begin
                cnt_reg[slot] <= cnt_reg[slot] + 1'b1;
                taken_reg     <= taken_reg + 1'b1;
            end
            if (cmd.commit && forb_inc)
            begin
                forb_total_reg <= forb_total_reg + 1'b1;
            end
        end
    end

    // Hold the item and refresh the look-ahead terms
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            idx_reg <= in_idx;
            lab_reg <= in_lab;
        end
        ge0_reg      <= ge0_c;
        ge1_reg      <= ge1_c;
        sum_ge_reg   <= sum_ge_c;
        sum1_ge_reg  <= sum1_ge_c;
        pre_done_reg <= done_now;
    end

    // Used map: sweep, set a bit, read a row
    always_ff @(posedge clk)
    begin
        if (cmd.clr_used)
        begin
            used_mem[cmd.clr_addr] <= '0;
        end
        else if (cmd.commit && take)
        begin
            used_mem[row] <= used_rd_reg | mask;
        end
        used_rd_reg <= used_mem[rd_row];
    end

    // Forbidden map: sweep, set a bit, read a row
    always_ff @(posedge clk)
    begin
        if (cmd.clr_forb)
        begin
            forb_mem[cmd.clr_addr] <= '0;
        end
        else if (cmd.commit && forb_inc)
        begin
            forb_mem[row] <= forb_rd_reg | mask;
        end
        forb_rd_reg <= forb_mem[rd_row];
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_accepted <= take;
            out_index    <= is_cand ? idx_reg : '0;
            out_label    <= is_cand ? lab_reg : '0;
            out_done     <= done_next;
            out_taken    <= taken_reg + SIZE_W'(take);
        end
    end

    a_take_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && take) |=> (taken_reg == $past(taken_reg) + 17'd1))
        else $error("accepted candidate not counted");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && status.in_start) |=> (taken_reg == '0))
        else $error("start item did not clear the taken count");

endmodule

`default_nettype wire
